// ===== rtl/bae_pkg.sv =====
// Shared types and constants of the binary arithmetic encoder.
package bae_pkg;

	localparam int BOUND_BITS = 32;
	localparam int BYTE_BITS  = 8;
	localparam int BURST_LEN  = 4;
	localparam int BURST_BITS = 2;

	localparam logic OP_ENCODE = 1'b0;
	localparam logic OP_FLUSH  = 1'b1;

	localparam logic [BOUND_BITS-1:0] LOW_RESET  = '0;
	localparam logic [BOUND_BITS-1:0] HIGH_RESET = '1;
	localparam logic [BYTE_BITS-1:0]  FILL_BYTE  = '1;

	typedef struct packed {
		logic flush;
		logic bit_value;
	} item_ctrl_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_UPD,
		ST_EMIT
	} coder_state_t;

endpackage

// ===== rtl/bae_front.sv =====
// Front end: accepts requests, clamps the probability and queues them for the coder.
module bae_front
	import bae_pkg::*;
#(
	parameter int PROB_BITS = 12
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  logic                 operation,
	input  logic                 bit_value,
	input  logic [PROB_BITS-1:0] probability,
	output logic                 item_valid,
	output item_ctrl_t           item_ctrl,
	output logic [PROB_BITS-1:0] item_prob,
	input  logic                 item_take
);

	localparam int DEPTH = 2;
	localparam int PTR_BITS = 1;
	localparam int CNT_BITS = 2;
	localparam logic [PROB_BITS-1:0] P_MIN = PROB_BITS'(1);
	localparam logic [PROB_BITS-1:0] P_MAX = {{(PROB_BITS-1){1'b1}}, 1'b0};

	item_ctrl_t           ctrl_q [DEPTH];
	logic [PROB_BITS-1:0] prob_q [DEPTH];
	logic [PTR_BITS-1:0]  wr_ptr_q;
	logic [PTR_BITS-1:0]  rd_ptr_q;
	logic [CNT_BITS-1:0]  cnt_q;
	logic                 push_ok;
	logic                 take_ok;
	logic [PROB_BITS-1:0] prob_clamped;
	item_ctrl_t           ctrl_in;

	assign full = (cnt_q == CNT_BITS'(DEPTH));
	assign push_ok = push && !full;
	assign take_ok = item_take && (cnt_q != '0);

	always_comb begin
		if (probability == '0) begin
			prob_clamped = P_MIN;
		end else if (&probability) begin
			prob_clamped = P_MAX;
		end else begin
			prob_clamped = probability;
		end
		ctrl_in.flush = (operation == OP_FLUSH);
		ctrl_in.bit_value = bit_value;
	end

	always_ff @(posedge clk) begin
		if (push_ok) begin
			ctrl_q[wr_ptr_q] <= ctrl_in;
			prob_q[wr_ptr_q] <= prob_clamped;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push_ok) begin
				wr_ptr_q <= wr_ptr_q + PTR_BITS'(1);
			end
			if (take_ok) begin
				rd_ptr_q <= rd_ptr_q + PTR_BITS'(1);
			end
			case ({push_ok, take_ok})
				2'b10: cnt_q <= cnt_q + CNT_BITS'(1);
				2'b01: cnt_q <= cnt_q - CNT_BITS'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	assign item_valid = (cnt_q != '0);
	assign item_ctrl = ctrl_q[rd_ptr_q];
	assign item_prob = prob_q[rd_ptr_q];

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_BITS'(DEPTH))
		else $error("request queue count out of range");

	a_no_take_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == '0) |=> (cnt_q <= CNT_BITS'(1)))
		else $error("request queue count jumped from empty");

endmodule

// ===== rtl/bae_back.sv =====
// Back end: interval update, byte renormalization and the result register.
module bae_back
	import bae_pkg::*;
#(
	parameter int PROB_BITS = 12
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	input  item_ctrl_t           item_ctrl,
	input  logic [PROB_BITS-1:0] item_prob,
	output logic                 item_take,
	output logic                 empty,
	input  logic                 pop,
	output logic [BYTE_BITS-1:0] out_byte,
	output logic                 run_end
);

	localparam int PROD_BITS = BOUND_BITS + PROB_BITS;

	coder_state_t              state_q;
	coder_state_t              state_d;
	logic [BOUND_BITS-1:0]     low_q;
	logic [BOUND_BITS-1:0]     high_q;
	logic [BOUND_BITS-1:0]     span_q;
	logic [PROB_BITS-1:0]      prob_q;
	logic [PROD_BITS-1:0]      prod_q;
	logic                      bit_q;
	logic                      flush_q;
	logic [BURST_BITS-1:0]     cnt_q;
	logic                      out_valid_q;
	logic [BYTE_BITS-1:0]      out_byte_q;
	logic                      run_end_q;

	logic                      pop_ok;
	logic                      can_write;
	logic                      agree;
	logic                      emit;
	logic                      last;
	logic                      write_out;
	logic [BOUND_BITS-1:0]     mid;

	assign pop_ok = pop && out_valid_q;
	assign can_write = !out_valid_q || pop_ok;
	assign agree = (low_q[31:24] == high_q[31:24]);
	assign mid = low_q + prod_q[PROB_BITS +: BOUND_BITS] + BOUND_BITS'(!bit_q);

	// A flush always sends four bytes; an encode sends while the top bytes agree.
	always_comb begin
		emit = flush_q || agree;
		if (flush_q) begin
			last = (cnt_q == BURST_BITS'(BURST_LEN - 1));
		end else begin
			last = (cnt_q == BURST_BITS'(BURST_LEN - 1)) || (low_q[23:16] != high_q[23:16]);
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					state_d = item_ctrl.flush ? ST_EMIT : ST_MUL;
				end
			end
			ST_MUL: state_d = ST_UPD;
			ST_UPD: state_d = ST_EMIT;
			ST_EMIT: begin
				if (!emit) begin
					state_d = ST_IDLE;
				end else if (can_write && last) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		item_take = 1'b0;
		write_out = 1'b0;
		case (state_q)
			ST_IDLE: item_take = item_valid;
			ST_EMIT: write_out = emit && can_write;
			default: begin
				item_take = 1'b0;
				write_out = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			low_q <= LOW_RESET;
			high_q <= HIGH_RESET;
			flush_q <= 1'b0;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (item_take) begin
				flush_q <= item_ctrl.flush;
				cnt_q <= '0;
			end
			if (state_q == ST_UPD) begin
				if (bit_q) begin
					high_q <= mid;
				end else begin
					low_q <= mid;
				end
			end
			if (write_out) begin
				high_q <= {high_q[23:0], FILL_BYTE};
				if (!flush_q) begin
					low_q <= {low_q[23:0], {BYTE_BITS{1'b0}}};
				end
				if (last) begin
					cnt_q <= '0;
				end else begin
					cnt_q <= cnt_q + BURST_BITS'(1);
				end
			end
			if (write_out) begin
				out_valid_q <= 1'b1;
			end else if (pop_ok) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_take) begin
			span_q <= high_q - low_q;
			prob_q <= item_prob;
			bit_q <= item_ctrl.bit_value;
		end
		if (state_q == ST_MUL) begin
			prod_q <= {{PROB_BITS{1'b0}}, span_q} * {{BOUND_BITS{1'b0}}, prob_q};
		end
		if (write_out) begin
			out_byte_q <= high_q[31:24];
			run_end_q <= last;
		end
	end

	assign empty = !out_valid_q;
	assign out_byte = out_byte_q;
	assign run_end = run_end_q;

	a_idle_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (cnt_q == '0))
		else $error("burst counter not cleared between requests");

	a_mul_after_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL) |-> ($past(state_q) == ST_IDLE && !flush_q))
		else $error("multiply step entered without an encode request");

	a_write_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		write_out |=> out_valid_q)
		else $error("emitted byte not held in result register");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !pop) |-> !write_out)
		else $error("result register overwritten before it was taken");

endmodule

// ===== rtl/binary_arithmetic_encoder.sv =====
// Top level of the binary arithmetic encoder: request queue front end and coder back end.
//
// Requests enter through push/full: operation selects encode (one bit with its
// probability of a one, in 2^-PROB_BITS units, clamped to 1 .. 2^PROB_BITS-2) or
// flush (the four bytes of the high bound). Coded bytes leave through empty/pop,
// most significant first; run_end marks the last byte caused by a request.
// A two-entry request queue parts the input from the coder, and a one-entry
// result register parts the coder from the receiver.
// Steps in the coder: an encode latches the request, multiplies, updates the bound
// and then emits its bytes, holding while the result register is full; the emit
// state is still entered when no byte is due. A flush goes from the latch straight
// to the emit state. The interval multiply of a 32-bit span by the probability is
// registered before the bound update.
// Reset clears the request queue and the result register and sets the bounds to zero and all ones.
// When the receiver stops popping, the coder holds its byte and stops, and the
// request queue fills up and raises full.
module binary_arithmetic_encoder
	import bae_pkg::*;
#(
	parameter int PROB_BITS = 12
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  logic                 operation,
	input  logic                 bit_value,
	input  logic [PROB_BITS-1:0] probability,
	output logic                 empty,
	input  logic                 pop,
	output logic [BYTE_BITS-1:0] out_byte,
	output logic                 run_end
);

	logic                 item_valid;
	item_ctrl_t           item_ctrl;
	logic [PROB_BITS-1:0] item_prob;
	logic                 item_take;

	bae_front #(
		.PROB_BITS(PROB_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.operation  (operation),
		.bit_value  (bit_value),
		.probability(probability),
		.item_valid (item_valid),
		.item_ctrl  (item_ctrl),
		.item_prob  (item_prob),
		.item_take  (item_take)
	);

	bae_back #(
		.PROB_BITS(PROB_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.item_ctrl (item_ctrl),
		.item_prob (item_prob),
		.item_take (item_take),
		.empty     (empty),
		.pop       (pop),
		.out_byte  (out_byte),
		.run_end   (run_end)
	);

endmodule

// ===== dv/bae_stream_checker.sv =====
// Checker for the binary arithmetic encoder: predicts the coded byte stream and compares it.
module bae_stream_checker
	import bae_pkg::*;
#(
	parameter int PROB_BITS = 12
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  logic                 full,
	input  logic                 operation,
	input  logic                 bit_value,
	input  logic [PROB_BITS-1:0] probability,
	input  logic                 empty,
	input  logic                 pop,
	input  logic [BYTE_BITS-1:0] out_byte,
	input  logic                 run_end,
	output int                   fail_count,
	output int                   pending,
	output int                   bytes_checked
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PROB_MAX = (1 << PROB_BITS) - 2;

	typedef struct packed {
		logic [BYTE_BITS-1:0] value;
		logic                 last;
	} coded_byte_t;

	logic [BOUND_BITS-1:0] low_q;
	logic [BOUND_BITS-1:0] high_q;
	coded_byte_t           coded_bytes_due[$];

	task automatic report_mismatch(input string what);
		fail_count++;
		if (fail_count <= 30) begin
			$display("[%0t] mismatch: %s", $time, what);
		end
	endtask

	// Advances the interval for one request and queues the bytes it should produce.
	task automatic code_request(input logic op, input logic bit_in,
			input logic [PROB_BITS-1:0] prob_in);
		logic [PROB_BITS-1:0]    p_clamped;
		logic [BOUND_BITS-1:0]   span;
		logic [BOUND_BITS-1:0]   mid;
		logic [2*BOUND_BITS-1:0] product;
		logic [BYTE_BITS-1:0]    burst[BURST_LEN];
		int                      n;
		coded_byte_t             cb;
		n = 0;
		if (op == OP_FLUSH) begin
			for (int i = 0; i < BURST_LEN; i++) begin
				burst[n] = high_q[BOUND_BITS-1 -: BYTE_BITS];
				n++;
				high_q = {high_q[BOUND_BITS-BYTE_BITS-1:0], FILL_BYTE};
			end
		end else begin
			if (prob_in == '0) begin
				p_clamped = PROB_BITS'(1);
			end else if (prob_in > PROB_MAX) begin
				p_clamped = PROB_BITS'(PROB_MAX);
			end else begin
				p_clamped = prob_in;
			end
			span = high_q - low_q;
			product = (2*BOUND_BITS)'(span) * (2*BOUND_BITS)'(p_clamped);
			mid = low_q + product[PROB_BITS +: BOUND_BITS];
			if (bit_in) begin
				high_q = mid;
			end else begin
				low_q = mid + BOUND_BITS'(1);
			end
			while (n < BURST_LEN &&
					low_q[BOUND_BITS-1 -: BYTE_BITS] == high_q[BOUND_BITS-1 -: BYTE_BITS]) begin
				burst[n] = high_q[BOUND_BITS-1 -: BYTE_BITS];
				n++;
				low_q = low_q << BYTE_BITS;
				high_q = {high_q[BOUND_BITS-BYTE_BITS-1:0], FILL_BYTE};
			end
		end
		for (int i = 0; i < n; i++) begin
			cb.value = burst[i];
			cb.last = (i == n - 1);
			coded_bytes_due = {coded_bytes_due, cb};
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		coded_byte_t want;
		if (!arst_n) begin
			low_q = LOW_RESET;
			high_q = HIGH_RESET;
			coded_bytes_due.delete();
			pending = 0;
		end else begin
			if (pop && !empty) begin
				bytes_checked++;
				if (coded_bytes_due.size() == 0) begin
					report_mismatch($sformatf("byte %02h arrived with nothing expected", out_byte));
				end else begin
					want = coded_bytes_due.pop_front();
					if (out_byte !== want.value) begin
						report_mismatch($sformatf("out_byte %02h, expected %02h",
							out_byte, want.value));
					end
					if (run_end !== want.last) begin
						report_mismatch($sformatf("run_end %0b, expected %0b on byte %02h",
							run_end, want.last, want.value));
					end
				end
			end
			if (push && !full) begin
				code_request(operation, bit_value, probability);
			end
			pending = coded_bytes_due.size();
		end
	end

endmodule

// ===== dv/binary_arithmetic_encoder_tb.sv =====
// Testbench top of the binary arithmetic encoder: clock, reset, request and pop stimulus, verdict.
module binary_arithmetic_encoder_tb
	import bae_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PROB_BITS = 12;
	localparam int RANDOM_REQUESTS = 110;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 push = 1'b0;
	logic                 full;
	logic                 operation = OP_ENCODE;
	logic                 bit_value = 1'b0;
	logic [PROB_BITS-1:0] probability = '0;
	logic                 empty;
	logic                 pop = 1'b0;
	logic [BYTE_BITS-1:0] out_byte;
	logic                 run_end;

	int fail_count;
	int pending;
	int bytes_checked;
	int burst_left = 0;
	int requests_sent = 0;
	int flushes_sent = 0;

	logic [7:0] stall_mask = 8'hFF;
	int         stall_phase = 0;
	int         stall_timer = 0;

	binary_arithmetic_encoder #(
		.PROB_BITS(PROB_BITS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.operation(operation),
		.bit_value(bit_value),
		.probability(probability),
		.empty(empty),
		.pop(pop),
		.out_byte(out_byte),
		.run_end(run_end)
	);

	bae_stream_checker #(
		.PROB_BITS(PROB_BITS)
	) i_checker (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.operation(operation),
		.bit_value(bit_value),
		.probability(probability),
		.empty(empty),
		.pop(pop),
		.out_byte(out_byte),
		.run_end(run_end),
		.fail_count(fail_count),
		.pending(pending),
		.bytes_checked(bytes_checked)
	);

	always #6 clk = ~clk;

	// The receiver changes its stall pattern every so often: no stalls, a random mask,
	// or a mask with a single bit set.
	always @(posedge clk) begin
		if (stall_timer == 0) begin
			stall_timer = $urandom_range(20, 60);
			case ($urandom_range(0, 2))
				0: begin
					stall_mask = 8'hFF;
				end
				1: begin
					stall_mask = 8'($urandom_range(1, 255));
				end
				default: begin
					stall_mask = 8'h01 << $urandom_range(0, 7);
				end
			endcase
		end
		stall_timer--;
		stall_phase = (stall_phase + 1) % 8;
		pop <= stall_mask[stall_phase];
	end

	// Sends one request, opening a new burst after a random gap when the current one is spent.
	task automatic send_request(input logic op, input logic bit_in,
			input logic [PROB_BITS-1:0] prob);
		int   gap;
		logic taken;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				push <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		push <= 1'b1;
		operation <= op;
		bit_value <= bit_in;
		probability <= prob;
		// The full flag only moves at the rising edge, so its value at the falling edge
		// decides whether the request is taken at the next rising edge.
		do begin
			@(negedge clk);
			taken = !full;
			@(posedge clk);
		end while (!taken);
		requests_sent++;
		if (op == OP_FLUSH) begin
			flushes_sent++;
		end
	endtask

	function automatic logic [PROB_BITS-1:0] pick_probability();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return PROB_BITS'($urandom_range(1, 30));
			3: return PROB_BITS'($urandom_range(4060, 4094));
			default: return PROB_BITS'($urandom_range(0, 4095));
		endcase
	endfunction

	initial begin
		logic [PROB_BITS-1:0] prob;
		logic                 bit_in;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: flush from reset, clamped probabilities, long squeezes.
		send_request(OP_FLUSH, 1'b1, 12'h000);
		send_request(OP_ENCODE, 1'b1, 12'h000);
		send_request(OP_ENCODE, 1'b0, 12'hFFF);
		send_request(OP_ENCODE, 1'b1, 12'hFFE);
		send_request(OP_ENCODE, 1'b0, 12'h000);
		send_request(OP_ENCODE, 1'b1, 12'h800);
		send_request(OP_ENCODE, 1'b0, 12'h001);
		repeat (6) send_request(OP_ENCODE, 1'b0, 12'hFFE);
		send_request(OP_FLUSH, 1'b0, 12'hFFF);
		repeat (3) send_request(OP_ENCODE, 1'b1, 12'h001);
		send_request(OP_ENCODE, 1'b0, 12'h800);
		send_request(OP_ENCODE, 1'b1, 12'hAAA);
		send_request(OP_ENCODE, 1'b0, 12'h555);
		send_request(OP_FLUSH, 1'b1, 12'h555);

		// Random part: mostly the likely bit under skewed probabilities, which narrows
		// the interval slowly, with some unlikely bits and the odd flush.
		for (int i = 0; i < RANDOM_REQUESTS; i++) begin
			prob = pick_probability();
			if ($urandom_range(0, 11) == 0) begin
				send_request(OP_FLUSH, 1'($urandom_range(0, 1)), prob);
			end else begin
				bit_in = ($urandom_range(0, 4) == 0) ? 1'($urandom_range(0, 1))
					: (prob >= 12'h800);
				send_request(OP_ENCODE, bit_in, prob);
			end
		end
		push <= 1'b0;

		@(negedge clk);
		while (pending != 0) begin
			@(negedge clk);
		end
		repeat (20) @(posedge clk);

		$display("Summary: %0d requests sent, %0d of them flushes; %0d coded bytes checked.",
			requests_sent, flushes_sent, bytes_checked);
		if (fail_count == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Timeout with %0d bytes still expected.", pending);
		$display("FAILED: results differ");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/bae_pkg.sv
rtl/bae_front.sv
rtl/bae_back.sv
rtl/binary_arithmetic_encoder.sv
dv/bae_stream_checker.sv
dv/binary_arithmetic_encoder_tb.sv
